>>> hdl/tbgd_pkg.sv
// Shared types and constants for the touch button gesture detector.
// Used by tbgd_button, touch_button_gesture_detector_top and tbgd_checker.
`default_nettype none

package tbgd_pkg;

	localparam int LANE_W    = 16;
	localparam int CFG_W     = 64;
	localparam int CFG_IDX_W = 2;
	localparam int MASK_W    = 4;
	localparam int BTN_IDX_W = 2;

	localparam logic [LANE_W-1:0] TMR_MAX = 16'hffff;

	localparam logic [CFG_IDX_W-1:0] CFG_DTAP_WIN = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_HOLD0    = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_HOLD1    = 2'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_REPEAT   = 2'd3;

	localparam logic CMD_FRAME = 1'b0;
	localparam logic CMD_RESET = 1'b1;

	typedef enum logic [2:0] {
		MODE_FREE    = 3'd0,
		MODE_HOLD    = 3'd1,
		MODE_DTCHECK = 3'd2,
		MODE_DT      = 3'd3,
		MODE_RESET   = 3'd4
	} btn_mode_t;

	typedef enum logic [2:0] {
		EV_NONE   = 3'd0,
		EV_TOUCH  = 3'd1,
		EV_HOLD0  = 3'd2,
		EV_HOLD1  = 3'd3,
		EV_REPEAT = 3'd4,
		EV_OUT    = 3'd5,
		EV_TAP    = 3'd6,
		EV_DTAP   = 3'd7
	} gesture_ev_t;

	typedef enum logic [1:0] {
		TC_UNCHANGED = 2'd0,
		TC_RELEASED  = 2'd1,
		TC_PRESSED   = 2'd2
	} touch_change_t;

	typedef struct packed {
		btn_mode_t         mode;
		logic              touched;
		logic [LANE_W-1:0] timer;
	} btn_state_t;

	typedef struct packed {
		logic [LANE_W-1:0] dtap_win;
		logic [LANE_W-1:0] hold0;
		logic [LANE_W-1:0] hold1;
		logic [LANE_W-1:0] repeat_iv;
	} btn_cfg_t;

	typedef struct packed {
		gesture_ev_t   gesture_ev;
		touch_change_t change;
	} btn_result_t;

endpackage

`default_nettype wire

>>> hdl/touch_button_gesture_detector_top.sv
// Top level of the touch button gesture detector: input stage, button state, result register.
// Depends on tbgd_pkg and tbgd_button.
//
//  port group   handshake            payload
//  cfg          cfg_wr_en            cfg_index, cfg_wdata
//  in           in_valid / in_stall  command, reset_button, screen_touched, screen_trigger,
//                                    inside_held_mask, inside_new_mask
//  out          out_valid / out_stall button_index, gesture_event, touch_change
//
// One request per cycle unless a stalled result holds the input stage.
// The request is registered, then all buttons update in parallel into the result register.
// Reset clears the button state, the configuration and both valid flags at once.
// A stalled result holds the input stage, and in_stall rises only then.
`default_nettype none

module touch_button_gesture_detector_top import tbgd_pkg::*; #(
	parameter int NUM_BUTTONS = 4
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_wr_en,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_wdata,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  logic                 command,
	input  logic [BTN_IDX_W-1:0] reset_button,
	input  logic                 screen_touched,
	input  logic                 screen_trigger,
	input  logic [MASK_W-1:0]    inside_held_mask,
	input  logic [MASK_W-1:0]    inside_new_mask,
	output logic                 out_valid,
	input  logic                 out_stall,
	output logic [BTN_IDX_W-1:0] button_index,
	output logic [2:0]           gesture_event,
	output logic [1:0]           touch_change
);

	logic [CFG_W-1:0] dtap_win_q;
	logic [CFG_W-1:0] hold0_q;
	logic [CFG_W-1:0] hold1_q;
	logic [CFG_W-1:0] repeat_q;

	logic                 valid_s1;
	logic                 command_s1;
	logic [BTN_IDX_W-1:0] reset_button_s1;
	logic                 touched_s1;
	logic                 trigger_s1;
	logic [MASK_W-1:0]    held_s1;
	logic [MASK_W-1:0]    fresh_s1;

	logic                 out_valid_q;
	logic [BTN_IDX_W-1:0] button_index_q;
	gesture_ev_t          gesture_event_q;
	touch_change_t        touch_change_q;

	logic advance;
	logic accept;
	logic hit;
	logic [BTN_IDX_W-1:0] sel_idx;
	btn_result_t          sel_res;

	btn_state_t  state_q [NUM_BUTTONS];
	btn_state_t  nxt     [NUM_BUTTONS];
	btn_result_t res     [NUM_BUTTONS];

	assign accept   = in_valid && !in_stall;
	assign advance  = valid_s1 && (!out_valid_q || !out_stall);
	assign in_stall = valid_s1 && out_valid_q && out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dtap_win_q <= '0;
			hold0_q    <= '0;
			hold1_q    <= '0;
			repeat_q   <= '0;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				CFG_DTAP_WIN: dtap_win_q <= cfg_wdata;
				CFG_HOLD0:    hold0_q    <= cfg_wdata;
				CFG_HOLD1:    hold1_q    <= cfg_wdata;
				CFG_REPEAT:   repeat_q   <= cfg_wdata;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			command_s1      <= command;
			reset_button_s1 <= reset_button;
			touched_s1      <= screen_touched;
			trigger_s1      <= screen_trigger;
			held_s1         <= inside_held_mask;
			fresh_s1        <= inside_new_mask;
		end
	end

	for (genvar i = 0; i < NUM_BUTTONS; i++) begin : g_btn
		btn_cfg_t lane_cfg;

		assign lane_cfg.dtap_win  = dtap_win_q[i*LANE_W +: LANE_W];
		assign lane_cfg.hold0     = hold0_q[i*LANE_W +: LANE_W];
		assign lane_cfg.hold1     = hold1_q[i*LANE_W +: LANE_W];
		assign lane_cfg.repeat_iv = repeat_q[i*LANE_W +: LANE_W];

		tbgd_button u_button (
			.cur   (state_q[i]),
			.cfg   (lane_cfg),
			.scr   (touched_s1),
			.trg   (touched_s1 && trigger_s1),
			.held  (held_s1[i]),
			.fresh (fresh_s1[i]),
			.nxt   (nxt[i]),
			.res   (res[i])
		);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				state_q[i].mode    <= MODE_FREE;
				state_q[i].touched <= 1'b0;
				state_q[i].timer   <= '0;
			end else if (advance) begin
				if (command_s1 == CMD_RESET) begin
					if (reset_button_s1 == BTN_IDX_W'(i)) begin
						state_q[i].mode  <= MODE_RESET;
						state_q[i].timer <= '0;
					end
				end else begin
					state_q[i] <= nxt[i];
				end
			end
		end
	end

	always_comb begin
		hit     = 1'b0;
		sel_idx = '0;
		sel_res = '0;
		for (int i = NUM_BUTTONS - 1; i >= 0; i--) begin
			if (res[i].gesture_ev != EV_NONE || res[i].change != TC_UNCHANGED) begin
				hit     = 1'b1;
				sel_idx = BTN_IDX_W'(i);
				sel_res = res[i];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= (command_s1 == CMD_FRAME) && hit;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && command_s1 == CMD_FRAME && hit) begin
			button_index_q  <= sel_idx;
			gesture_event_q <= sel_res.gesture_ev;
			touch_change_q  <= sel_res.change;
		end
	end

	assign out_valid     = out_valid_q;
	assign button_index  = button_index_q;
	assign gesture_event = gesture_event_q;
	assign touch_change  = touch_change_q;

endmodule

`default_nettype wire

>>> hdl/tbgd_button.sv
// Next-state and event logic of one button for one frame.
// Depends on tbgd_pkg for the state, lane and result types.
`default_nettype none

module tbgd_button import tbgd_pkg::*; (
	input  btn_state_t  cur,
	input  btn_cfg_t    cfg,
	input  logic        scr,
	input  logic        trg,
	input  logic        held,
	input  logic        fresh,
	output btn_state_t  nxt,
	output btn_result_t res
);

	logic              t;
	logic [LANE_W-1:0] tmr_inc;

	assign t       = scr && (cur.touched ? held : fresh);
	assign tmr_inc = (cur.timer != TMR_MAX) ? cur.timer + 16'd1 : cur.timer;

	always_comb begin
		nxt            = cur;
		nxt.touched    = t;
		res.gesture_ev = EV_NONE;
		if (t != cur.touched) begin
			res.change = t ? TC_PRESSED : TC_RELEASED;
		end else begin
			res.change = TC_UNCHANGED;
		end
		case (cur.mode)
			MODE_HOLD: begin
				nxt.timer = tmr_inc;
				if (t) begin
					if (cfg.hold0 == tmr_inc) begin
						res.gesture_ev = EV_HOLD0;
					end else if (cfg.hold1 == tmr_inc) begin
						res.gesture_ev = EV_HOLD1;
					end else if (cfg.repeat_iv != '0 && tmr_inc >= cfg.repeat_iv) begin
						nxt.timer      = '0;
						res.gesture_ev = EV_REPEAT;
					end
				end else if (scr) begin
					nxt.mode       = MODE_FREE;
					nxt.timer      = '0;
					res.gesture_ev = EV_OUT;
				end else if (cfg.dtap_win != '0) begin
					nxt.mode = MODE_DTCHECK;
				end else begin
					nxt.mode       = MODE_FREE;
					nxt.timer      = '0;
					res.gesture_ev = EV_TAP;
				end
			end
			MODE_DTCHECK: begin
				nxt.timer = tmr_inc;
				if (tmr_inc > cfg.dtap_win) begin
					nxt.mode       = MODE_FREE;
					nxt.timer      = '0;
					res.gesture_ev = EV_TAP;
				end else if (t && trg) begin
					nxt.mode       = MODE_DT;
					nxt.timer      = '0;
					res.gesture_ev = EV_DTAP;
				end
			end
			MODE_DT: begin
				if (t) begin
					nxt.timer = tmr_inc;
				end else begin
					nxt.mode  = MODE_FREE;
					nxt.timer = '0;
				end
			end
			MODE_RESET: begin
				if (!t) begin
					nxt.mode  = MODE_FREE;
					nxt.timer = '0;
				end
			end
			default: begin
				if (t && trg) begin
					nxt.mode       = MODE_HOLD;
					nxt.timer      = '0;
					res.gesture_ev = EV_TOUCH;
				end
			end
		endcase
	end

endmodule

`default_nettype wire

>>> hdl/tbgd_checker.sv
// Port-level checks on the gesture detector, attached to the top level by bind.
// Depends on tbgd_pkg for the event and touch-change codes.
`default_nettype none

module tbgd_checker import tbgd_pkg::*; (
	input logic                 clk,
	input logic                 arst_n,
	input logic                 in_valid,
	input logic                 in_stall,
	input logic                 out_valid,
	input logic                 out_stall,
	input logic [BTN_IDX_W-1:0] button_index,
	input logic [2:0]           gesture_event,
	input logic [1:0]           touch_change
);

	a_stall_only_on_back_pressure: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (out_valid && out_stall))
		else $error("input stalled without a held result");

	a_result_follows_request: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_valid && !in_stall, 2))
		else $error("result appeared without a request two cycles before");

	a_result_not_empty: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (gesture_event != EV_NONE || touch_change != TC_UNCHANGED))
		else $error("result with neither event nor touch change");

	a_touch_change_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (touch_change == TC_UNCHANGED || touch_change == TC_RELEASED ||
			touch_change == TC_PRESSED))
		else $error("touch change code out of range");

	a_stalled_result_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |=> (out_valid && $stable(button_index) &&
			$stable(gesture_event) && $stable(touch_change)))
		else $error("stalled result changed");

endmodule

bind touch_button_gesture_detector_top tbgd_checker u_tbgd_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.in_valid      (in_valid),
	.in_stall      (in_stall),
	.out_valid     (out_valid),
	.out_stall     (out_stall),
	.button_index  (button_index),
	.gesture_event (gesture_event),
	.touch_change  (touch_change)
);

`default_nettype wire
